// ===== hw/rtl/region_scanline_mask_rasterizer_unit_macros.svh =====
// Assertion macros used by the checker file of the region rasterizer.
// Depends on nothing; included by rsmr_checker.sv.
`ifndef REGION_SCANLINE_MASK_RASTERIZER_UNIT_MACROS_SVH
`define REGION_SCANLINE_MASK_RASTERIZER_UNIT_MACROS_SVH

// assert a property that holds at every clock edge out of reset
`define RSMR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("rsmr assertion failed");

// assert that cons holds in the cycle after ante
`define RSMR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rsmr assertion failed");

`endif

// ===== hw/rtl/rsmr_pkg.sv =====
`timescale 1ns / 1ps
// Types and constants of the region scanline mask rasterizer.
// Depends on nothing; imported by the front, queue, engine, top level and testbench.
package rsmr_pkg;

  localparam logic [15:0] END_MARK  = 16'h7fff;
  localparam logic [15:0] RECT_SIZE = 16'd10;
  localparam int unsigned CHUNK_BITS = 64;
  localparam int unsigned MAX_CHUNKS = 16;
  localparam logic [10:0] DW_RESET = 11'd1024;
  localparam logic [10:0] DH_RESET = 11'd768;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE, PH_TOP, PH_LEFT, PH_BOTTOM, PH_RIGHT, PH_ROW, PH_BEGIN, PH_END
  } phase_e;

  typedef enum logic [1:0] {
    OP_CLEAR, OP_TOGGLE, OP_EMIT
  } op_e;

  typedef enum logic [1:0] {
    MODE_IN, MODE_OUT, MODE_RSET, MODE_RCLR
  } mode_e;

  typedef struct packed {
    op_e        op;
    mode_e      mode;
    logic [9:0] row_first;
    logic [9:0] row_last;
    logic [9:0] x0;
    logic [9:0] xm1;
  } cmd_t;

  function automatic logic [10:0] clamp_coord(logic signed [15:0] v, logic [10:0] hi);
    logic [10:0] r;
    if (v < 0) begin
      r = 11'd0;
    end else if (v[14:0] > {4'd0, hi}) begin
      r = hi;
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

  function automatic logic [10:0] min11(logic [10:0] a, logic [10:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/rsmr_if.sv =====
`timescale 1ns / 1ps
// Channel interfaces: region words in, chunk items out, register writes.
// Depends on nothing.
interface rsmr_in_if ();
  logic        valid;
  logic        ready;
  logic [15:0] region_word;
  logic        first_word;
  logic        polarity_in;
  modport source (output valid, region_word, first_word, polarity_in, input ready);
  modport sink (input valid, region_word, first_word, polarity_in, output ready);
endinterface

interface rsmr_out_if ();
  logic        valid;
  logic        ready;
  logic [9:0]  row_first;
  logic [9:0]  row_last;
  logic [3:0]  chunk_index;
  logic [63:0] set_bits;
  logic [63:0] clear_bits;
  logic        last_of_run;
  modport source (output valid, row_first, row_last, chunk_index, set_bits, clear_bits,
                  last_of_run, input ready);
  modport sink (input valid, row_first, row_last, chunk_index, set_bits, clear_bits,
                last_of_run, output ready);
endinterface

interface rsmr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [10:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/rsmr_front.sv =====
`timescale 1ns / 1ps
// Record parser: takes region words, tracks the box and row, issues commands.
// Depends on rsmr_pkg.
module rsmr_front import rsmr_pkg::*; #(
  parameter int unsigned LINE_WIDTH = 1024,
  parameter int unsigned ROW_LIMIT  = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] region_word_i,
  input  logic        first_word_i,
  input  logic        polarity_in_i,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i,
  output logic        push_o,
  output cmd_t        cmd_o,
  input  logic        full_i
);
  localparam int unsigned CHUNKS = (LINE_WIDTH / CHUNK_BITS > MAX_CHUNKS) ?
                                   MAX_CHUNKS : LINE_WIDTH / CHUNK_BITS;
  localparam logic [10:0] XCAP = 11'(CHUNKS * CHUNK_BITS);
  localparam logic [10:0] YCAP = 11'((ROW_LIMIT > 1024) ? 1024 : ROW_LIMIT);

  phase_e phase_q, phase_d;
  logic [10:0] dw_q, dh_q;
  logic signed [15:0] top_q, left_q, bottom_q, right_q, cur_q, pend_q;
  logic signed [15:0] top_d, left_d, bottom_d, right_d, cur_d, pend_d;
  logic [15:0] size_q, size_d;
  logic pol_q, pol_d;

  logic accept;
  logic signed [15:0] sw, r0s, r1s, ytop, ybot;
  logic [10:0] wx, hy, x0, x1, y0, y1, b, e;

  assign in_ready_o = !full_i;
  assign accept = in_valid_i && !full_i;
  assign sw = signed'(region_word_i);
  assign wx = min11(dw_q, XCAP);
  assign hy = min11(dh_q, YCAP);

  always_comb begin
    phase_d = phase_q;
    top_d = top_q;
    left_d = left_q;
    bottom_d = bottom_q;
    right_d = right_q;
    cur_d = cur_q;
    pend_d = pend_q;
    size_d = size_q;
    pol_d = pol_q;
    push_o = 1'b0;
    cmd_o = '0;
    x0 = clamp_coord(left_q, wx);
    x1 = clamp_coord(sw, wx);
    r0s = (cur_q < top_q) ? top_q : cur_q;
    r1s = (sw > bottom_q) ? bottom_q : sw;
    ytop = (phase_q == PH_RIGHT) ? top_q : r0s;
    ybot = (phase_q == PH_RIGHT) ? bottom_q : r1s;
    y0 = clamp_coord(ytop, hy);
    y1 = clamp_coord(ybot, hy);
    b = clamp_coord(pend_q, wx);
    e = x1;
    if (phase_q == PH_ROW) begin
      x1 = clamp_coord(right_q, wx);
    end
    if (accept) begin
      if (first_word_i) begin
        size_d = region_word_i;
        pol_d = polarity_in_i;
        phase_d = PH_TOP;
        push_o = 1'b1;
        cmd_o.op = OP_CLEAR;
      end else begin
        case (phase_q)
          PH_TOP: begin
            top_d = sw;
            phase_d = PH_LEFT;
          end
          PH_LEFT: begin
            left_d = sw;
            phase_d = PH_BOTTOM;
          end
          PH_BOTTOM: begin
            bottom_d = sw;
            phase_d = PH_RIGHT;
          end
          PH_RIGHT: begin
            right_d = sw;
            cmd_o.op = OP_EMIT;
            cmd_o.mode = pol_q ? MODE_RSET : MODE_RCLR;
            if (size_q == RECT_SIZE) begin
              push_o = (y0 < y1) && (x0 < x1);
              phase_d = PH_IDLE;
            end else begin
              cur_d = top_q;
              phase_d = PH_ROW;
            end
          end
          PH_ROW: begin
            cmd_o.op = OP_EMIT;
            cmd_o.mode = pol_q ? MODE_IN : MODE_OUT;
            push_o = (y0 < y1) && (x0 < x1);
            cur_d = sw;
            phase_d = (region_word_i == END_MARK) ? PH_IDLE : PH_BEGIN;
          end
          PH_BEGIN: begin
            if (region_word_i == END_MARK) begin
              phase_d = PH_ROW;
            end else begin
              pend_d = sw;
              phase_d = PH_END;
            end
          end
          PH_END: begin
            cmd_o.op = OP_TOGGLE;
            push_o = b < e;
            phase_d = PH_BEGIN;
          end
          default: begin
          end
        endcase
      end
    end
    cmd_o.row_first = y0[9:0];
    cmd_o.row_last = 10'(y1 - 11'd1);
    if (cmd_o.op == OP_TOGGLE) begin
      cmd_o.x0 = b[9:0];
      cmd_o.xm1 = 10'(e - 11'd1);
    end else begin
      cmd_o.x0 = x0[9:0];
      cmd_o.xm1 = 10'(x1 - 11'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      top_q <= '0;
      left_q <= '0;
      bottom_q <= '0;
      right_q <= '0;
      cur_q <= '0;
      pend_q <= '0;
      size_q <= '0;
      pol_q <= 1'b1;
      dw_q <= DW_RESET;
      dh_q <= DH_RESET;
    end else begin
      phase_q <= phase_d;
      top_q <= top_d;
      left_q <= left_d;
      bottom_q <= bottom_d;
      right_q <= right_d;
      cur_q <= cur_d;
      pend_q <= pend_d;
      size_q <= size_d;
      pol_q <= pol_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_WIDTH:  dw_q <= cfg_data_i;
          CFG_HEIGHT: dh_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/rsmr_cmd_fifo.sv =====
`timescale 1ns / 1ps
// Two-entry command queue between parser and chunk engine.
// Depends on rsmr_pkg.
module rsmr_cmd_fifo import rsmr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);
  cmd_t mem_q [2];
  logic wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign cmd_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, push_i} - {1'b0, pop_i});
    end
  end

endmodule

// ===== hw/rtl/rsmr_back.sv =====
`timescale 1ns / 1ps
// Chunk engine: holds the line store, toggles spans, emits chunk items.
// Depends on rsmr_pkg.
module rsmr_back import rsmr_pkg::*; #(
  parameter int unsigned LINE_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  cmd_t        cmd_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [9:0]  row_first_o,
  output logic [9:0]  row_last_o,
  output logic [3:0]  chunk_index_o,
  output logic [63:0] set_bits_o,
  output logic [63:0] clear_bits_o,
  output logic        last_of_run_o
);
  localparam int unsigned CHUNKS = (LINE_WIDTH / CHUNK_BITS > MAX_CHUNKS) ?
                                   MAX_CHUNKS : LINE_WIDTH / CHUNK_BITS;
  localparam int unsigned IDXW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

  logic [63:0] line_q [CHUNKS];
  logic active_q;
  cmd_t cmd_q;
  logic [3:0] c_q;
  logic [3:0] cend;
  logic [5:0] lo;
  logic [6:0] hi;
  logic [63:0] mask, line_rd;
  logic out_free, step, last;

  assign cend = cmd_q.xm1[9:6];
  assign last = c_q == cend;
  assign lo = (c_q == cmd_q.x0[9:6]) ? cmd_q.x0[5:0] : 6'd0;
  assign hi = last ? 7'({1'b0, cmd_q.xm1[5:0]} + 7'd1) : 7'd64;
  assign mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (7'd64 - hi));
  assign line_rd = line_q[c_q[IDXW-1:0]];
  assign out_free = !out_valid_o || out_ready_i;
  assign step = active_q && ((cmd_q.op != OP_EMIT) || out_free);
  assign pop_o = !active_q && !empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      out_valid_o <= 1'b0;
      cmd_q <= '0;
      c_q <= '0;
      row_first_o <= '0;
      row_last_o <= '0;
      chunk_index_o <= '0;
      set_bits_o <= '0;
      clear_bits_o <= '0;
      last_of_run_o <= 1'b0;
      for (int i = 0; i < CHUNKS; i++) line_q[i] <= '0;
    end else begin
      if (out_ready_i && !(step && (cmd_q.op == OP_EMIT))) out_valid_o <= 1'b0;
      if (pop_o) begin
        active_q <= 1'b1;
        cmd_q <= cmd_i;
        c_q <= cmd_i.x0[9:6];
      end
      if (step) begin
        c_q <= 4'(c_q + 4'd1);
        case (cmd_q.op)
          OP_CLEAR: begin
            for (int i = 0; i < CHUNKS; i++) line_q[i] <= '0;
            active_q <= 1'b0;
          end
          OP_TOGGLE: begin
            line_q[c_q[IDXW-1:0]] <= line_rd ^ mask;
            if (last) active_q <= 1'b0;
          end
          OP_EMIT: begin
            out_valid_o <= 1'b1;
            row_first_o <= cmd_q.row_first;
            row_last_o <= cmd_q.row_last;
            chunk_index_o <= c_q;
            last_of_run_o <= last;
            case (cmd_q.mode)
              MODE_IN:   set_bits_o <= line_rd & mask;
              MODE_OUT:  set_bits_o <= ~line_rd & mask;
              MODE_RSET: set_bits_o <= mask;
              default:   set_bits_o <= '0;
            endcase
            clear_bits_o <= (cmd_q.mode == MODE_RCLR) ? mask : '0;
            if (last) active_q <= 1'b0;
          end
          default: active_q <= 1'b0;
        endcase
      end
    end
  end

endmodule

// ===== hw/rtl/region_scanline_mask_rasterizer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the region scanline mask rasterizer.
// Depends on rsmr_pkg, rsmr_if, rsmr_front, rsmr_cmd_fifo, rsmr_back.
//
//  port    dir  carries
//  in_i    in   region_word, first_word, polarity_in
//  cfg_i   in   index 0 display_width, index 1 display_height
//  out_o   out  row_first, row_last, chunk_index, set_bits, clear_bits, last_of_run
//
// The parser takes a word while the command queue is not full; the chunk engine
// loads each span toggle or emit, then walks it one 64-pixel chunk per step, up
// to LINE_WIDTH/64 (at most 16) chunks; emits wait while the output stalls. A
// region start clears the line store; reset clears it and all control state.
// A two-entry command queue lets the parser run ahead while the output stalls.
module region_scanline_mask_rasterizer_unit import rsmr_pkg::*; #(
  parameter int unsigned LINE_WIDTH = 1024,
  parameter int unsigned ROW_LIMIT  = 1024
) (
  input logic          clk_i,
  input logic          rst_ni,
  rsmr_in_if.sink      in_i,
  rsmr_cfg_if.sink     cfg_i,
  rsmr_out_if.source   out_o
);
  logic push, full, pop, empty;
  cmd_t cmd_in, cmd_out;

  assign cfg_i.ready = 1'b1;

  rsmr_front #(.LINE_WIDTH(LINE_WIDTH), .ROW_LIMIT(ROW_LIMIT)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_ready_o(in_i.ready),
    .region_word_i(in_i.region_word), .first_word_i(in_i.first_word),
    .polarity_in_i(in_i.polarity_in),
    .cfg_valid_i(cfg_i.valid), .cfg_index_i(cfg_i.index), .cfg_data_i(cfg_i.data),
    .push_o(push), .cmd_o(cmd_in), .full_i(full)
  );

  rsmr_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .cmd_i(cmd_in), .full_o(full),
    .pop_i(pop), .empty_o(empty), .cmd_o(cmd_out)
  );

  rsmr_back #(.LINE_WIDTH(LINE_WIDTH)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(cmd_out), .pop_o(pop),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready),
    .row_first_o(out_o.row_first), .row_last_o(out_o.row_last),
    .chunk_index_o(out_o.chunk_index), .set_bits_o(out_o.set_bits),
    .clear_bits_o(out_o.clear_bits), .last_of_run_o(out_o.last_of_run)
  );

endmodule

// ===== hw/rtl/rsmr_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the rasterizer output channel, bound to the top level.
// Depends on region_scanline_mask_rasterizer_unit_macros.svh.
`include "region_scanline_mask_rasterizer_unit_macros.svh"
module rsmr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [9:0]  row_first_i,
  input logic [9:0]  row_last_i,
  input logic [63:0] set_bits_i,
  input logic [63:0] clear_bits_i
);
  `RSMR_ASSERT_NEXT(a_hold_valid, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `RSMR_ASSERT_NEXT(a_hold_rows, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(row_first_i))
  `RSMR_ASSERT(a_rows_order, clk_i, rst_ni, !out_valid_i || (row_first_i <= row_last_i))
  `RSMR_ASSERT(a_set_or_clear, clk_i, rst_ni, !out_valid_i || (set_bits_i == '0) || (clear_bits_i == '0))
endmodule

bind region_scanline_mask_rasterizer_unit rsmr_checker u_rsmr_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready),
  .row_first_i(out_o.row_first), .row_last_i(out_o.row_last),
  .set_bits_i(out_o.set_bits), .clear_bits_i(out_o.clear_bits)
);

// ===== bench/rsmr_tb_if.sv =====
`timescale 1ns / 1ps
// Bench-side note: the channel interfaces come from the RTL file rsmr_if.sv.
// Depends on nothing; declares a single helper type used by the scoreboard.
package rsmr_tb_pkg;
  typedef struct packed {
    logic [9:0]  row_first;
    logic [9:0]  row_last;
    logic [3:0]  chunk_index;
    logic [63:0] set_bits;
    logic [63:0] clear_bits;
    logic        last_of_run;
  } chunk_t;
endpackage

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Testbench of region_scanline_mask_rasterizer_unit: region records in, mask chunks out.
// Depends on rsmr_pkg, rsmr_if and rsmr_tb_pkg; a scoreboard class predicts every chunk.
module testbench;
  import rsmr_pkg::*;
  import rsmr_tb_pkg::*;

  class chunk_scoreboard;
    logic [10:0] disp_w, disp_h;
    logic [63:0] line_store [16];
    int          cur_row, top, left, bottom, right, pend_begin;
    logic [15:0] rec_size;
    phase_e      phase;
    logic        pol_in;
    chunk_t      pending_chunks [$];
    int          mismatches, checked, words_seen;

    function void reset_state();
      disp_w = DW_RESET;
      disp_h = DH_RESET;
      foreach (line_store[i]) line_store[i] = '0;
      cur_row = 0; top = 0; left = 0; bottom = 0; right = 0; pend_begin = 0;
      rec_size = '0;
      phase = PH_IDLE;
      pol_in = 1'b1;
    endfunction

    function int clip(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic [63:0] span(int lo, int hi);
      logic [63:0] m;
      m = (hi - lo >= 64) ? '1 : ((64'd1 << (hi - lo)) - 64'd1);
      return m << lo;
    endfunction

    function void push_chunks(int r0, int r1, int x0, int x1, mode_e mode);
      chunk_t ck;
      int lo, hi;
      if (r0 >= r1 || x0 >= x1) return;
      for (int c = x0 / 64; c <= (x1 - 1) / 64 && c < 16; c++) begin
        lo = x0 > c * 64 ? x0 - c * 64 : 0;
        hi = x1 < c * 64 + 64 ? x1 - c * 64 : 64;
        ck = '0;
        ck.row_first = r0[9:0];
        ck.row_last = 10'(r1 - 1);
        ck.chunk_index = c[3:0];
        case (mode)
          MODE_IN:   ck.set_bits = line_store[c] & span(lo, hi);
          MODE_OUT:  ck.set_bits = ~line_store[c] & span(lo, hi);
          MODE_RSET: ck.set_bits = span(lo, hi);
          default:   ck.clear_bits = span(lo, hi);
        endcase
        pending_chunks = {pending_chunks, ck};
      end
    endfunction

    function void note_word(logic [15:0] word, logic first, logic pol);
      int sw, w, h, r0, r1, b, e, lo, hi, before_n;
      sw = $signed(word);
      w = disp_w > 1024 ? 1024 : disp_w;
      h = disp_h > 1024 ? 1024 : disp_h;
      before_n = pending_chunks.size();
      words_seen++;
      if (first) begin
        rec_size = word;
        pol_in = pol;
        foreach (line_store[i]) line_store[i] = '0;
        phase = PH_TOP;
        return;
      end
      case (phase)
        PH_TOP: begin top = sw; phase = PH_LEFT; end
        PH_LEFT: begin left = sw; phase = PH_BOTTOM; end
        PH_BOTTOM: begin bottom = sw; phase = PH_RIGHT; end
        PH_RIGHT: begin
          right = sw;
          if (rec_size == RECT_SIZE) begin
            push_chunks(clip(top, 0, h), clip(bottom, 0, h), clip(left, 0, w),
                        clip(right, 0, w), pol_in ? MODE_RSET : MODE_RCLR);
            phase = PH_IDLE;
          end else begin
            cur_row = top;
            phase = PH_ROW;
          end
        end
        PH_ROW: begin
          r0 = cur_row < top ? top : cur_row;
          r1 = sw > bottom ? bottom : sw;
          push_chunks(clip(r0, 0, h), clip(r1, 0, h), clip(left, 0, w),
                      clip(right, 0, w), pol_in ? MODE_IN : MODE_OUT);
          cur_row = sw;
          phase = (word == END_MARK) ? PH_IDLE : PH_BEGIN;
        end
        PH_BEGIN: begin
          if (word == END_MARK) phase = PH_ROW;
          else begin
            pend_begin = sw;
            phase = PH_END;
          end
        end
        PH_END: begin
          b = clip(pend_begin, 0, w);
          e = clip(sw, 0, w);
          if (b < e) begin
            for (int c = b / 64; c <= (e - 1) / 64 && c < 16; c++) begin
              lo = b > c * 64 ? b - c * 64 : 0;
              hi = e < c * 64 + 64 ? e - c * 64 : 64;
              line_store[c] ^= span(lo, hi);
            end
          end
          phase = PH_BEGIN;
        end
        default: ;
      endcase
      if (pending_chunks.size() > before_n)
        pending_chunks[pending_chunks.size() - 1].last_of_run = 1'b1;
    endfunction

    function void check_chunk(chunk_t got);
      chunk_t exp_c;
      checked++;
      if (pending_chunks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected chunk %p", got);
        return;
      end
      exp_c = pending_chunks.pop_front();
      if (exp_c !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("chunk differs: expected %p got %p", exp_c, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  rsmr_in_if  in_ch ();
  rsmr_cfg_if cfg_ch ();
  rsmr_out_if out_ch ();

  region_scanline_mask_rasterizer_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .cfg_i(cfg_ch.sink),
    .out_o(out_ch.source)
  );

  chunk_scoreboard sb;
  int cycles;
  bit timed_out;
  bit sink_quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 900000) begin
      $display("timeout");
      $display("region_scanline_mask_rasterizer_unit: mismatch");
      $finish;
    end
  end

  // receiver: random stalls unless sink_quiet, checked at the edge
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = sink_quiet ? 0 : ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13));
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
      sb.check_chunk({out_ch.row_first, out_ch.row_last, out_ch.chunk_index,
                      out_ch.set_bits, out_ch.clear_bits, out_ch.last_of_run});
    end
  end

  task automatic send_word(logic [15:0] word, logic first = 1'b0, logic pol = 1'b1,
                           bit no_gap = 1'b0);
    int gap;
    gap = (no_gap || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.region_word <= word;
    in_ch.first_word <= first;
    in_ch.polarity_in <= pol;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_word(word, first, pol);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_chunks.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [10:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_WIDTH) sb.disp_w = val;
    else sb.disp_h = val;
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] coord(int span_max);
    case ($urandom_range(0, 9))
      0: return 16'($urandom_range(0, 65535));
      1: return 16'(16'hffff - $urandom_range(0, 40));
      default: return 16'($urandom_range(0, span_max));
    endcase
  endfunction

  // well-formed region with random content, sometimes cut short or noisy
  task automatic send_region(int span_max);
    int rows, pairs, row;
    logic pol;
    pol = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 3) == 0) begin
      send_word(16'd10, 1'b1, pol);
      repeat (4) send_word(coord(span_max));
      return;
    end
    send_word(16'($urandom_range(11, 400)), 1'b1, pol);
    repeat (4) send_word(coord(span_max));
    rows = $urandom_range(1, 5);
    row = $urandom_range(0, 20);
    for (int r = 0; r < rows; r++) begin
      row += $urandom_range(0, 30) - 3;
      send_word(row[15:0]);
      pairs = $urandom_range(0, 3);
      for (int p = 0; p < pairs; p++) begin
        send_word(coord(span_max));
        send_word(coord(span_max));
      end
      if ($urandom_range(0, 19) == 0) return;
      send_word(END_MARK);
    end
    send_word(END_MARK);
  endtask

  initial begin
    int n;
    cycles = 0;
    sink_quiet = 1'b0;
    sb = new();
    sb.reset_state();
    sb.mismatches = 0; sb.checked = 0; sb.words_seen = 0;
    rst_ni = 1'b0;
    in_ch.valid = 1'b0; in_ch.region_word = '0; in_ch.first_word = 1'b0;
    in_ch.polarity_in = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.index = CFG_WIDTH; cfg_ch.data = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part with an idle word, a full set rectangle, an empty clear rectangle and two regions
    send_word(16'h1234);
    send_word(16'd10, 1'b1, 1'b1);
    send_word(16'd0); send_word(16'd0); send_word(16'd1024); send_word(16'd1024);
    send_word(16'd10, 1'b1, 1'b0);
    send_word(16'h8000); send_word(16'h8000); send_word(16'h7ffe); send_word(16'hffff);
    send_word(16'd50, 1'b1, 1'b1);
    send_word(16'd2); send_word(16'd3); send_word(16'd40); send_word(16'd1000);
    send_word(16'd5); send_word(16'd10); send_word(16'd700);
    send_word(16'd90); send_word(16'd20);
    send_word(END_MARK);
    send_word(16'd4, 1'b1, 1'b0);
    send_word(16'd0); send_word(16'd0); send_word(16'd30); send_word(16'd1023);
    send_word(16'd9); send_word(16'd0); send_word(16'hffff);
    send_word(END_MARK); send_word(16'd30); send_word(END_MARK);
    drain();

    write_reg(CFG_WIDTH, 11'd1); write_reg(CFG_HEIGHT, 11'd1);
    for (n = 0; n < 4; n++) send_region(4);
    drain();
    write_reg(CFG_WIDTH, 11'd2047); write_reg(CFG_HEIGHT, 11'd2047);
    for (n = 0; n < 8; n++) send_region(1100);
    drain();
    write_reg(CFG_WIDTH, 11'd0); write_reg(CFG_HEIGHT, 11'd0);
    for (n = 0; n < 2; n++) send_region(100);
    drain();
    write_reg(CFG_WIDTH, 11'd200); write_reg(CFG_HEIGHT, 11'd64);
    sink_quiet = 1'b1;
    while (sb.words_seen < 420) begin
      if ($urandom_range(0, 9) == 0) sink_quiet = ~sink_quiet;
      if ($urandom_range(0, 15) == 0)
        send_word(16'($urandom_range(0, 65535)), 1'b0, 1'($urandom_range(0, 1)), 1'b1);
      else send_region($urandom_range(0, 3) == 0 ? 1100 : 260);
    end
    drain();
    $display("covered %0d region words and %0d chunks over five display settings",
             sb.words_seen, sb.checked);
    if (sb.mismatches == 0 && sb.pending_chunks.size() == 0) begin
      $display("region_scanline_mask_rasterizer_unit: match");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("region_scanline_mask_rasterizer_unit: mismatch");
    end
    $finish;
  end
endmodule

// ===== region_scanline_mask_rasterizer_unit.f =====
+incdir+hw/rtl
hw/rtl/rsmr_pkg.sv
hw/rtl/rsmr_if.sv
hw/rtl/rsmr_front.sv
hw/rtl/rsmr_cmd_fifo.sv
hw/rtl/rsmr_back.sv
hw/rtl/region_scanline_mask_rasterizer_unit.sv
hw/rtl/rsmr_checker.sv
bench/rsmr_tb_if.sv
bench/testbench.sv
